### rtl/mpow_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the matrix power block.
package mpow_pkg;

	localparam int MAX_SIZE  = 8;
	localparam int IDX_W     = $clog2(MAX_SIZE);
	localparam int SIZE_W    = 4;
	localparam int DATA_W    = 32;
	localparam int PWR_W     = 31;
	localparam int BIT_W     = $clog2(PWR_W);
	localparam int DRAIN_W   = $clog2(MAX_SIZE + 2);
	// drain count at which the last new-column write has landed after the last issue
	localparam logic [DRAIN_W-1:0] DRAIN_LEN = DRAIN_W'(MAX_SIZE + 1);
	localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(2);

	typedef logic [MAX_SIZE-1:0][DATA_W-1:0] col_t;

	// row-element token passed along the cell row
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  t;
		logic [DATA_W-1:0] a;
	} token_t;

	typedef struct packed {
		logic              init;
		logic              copy;
		logic              use_base;
		logic              load_we;
		logic [IDX_W-1:0]  load_row;
		logic [IDX_W-1:0]  load_col;
		logic [DATA_W-1:0] load_data;
	} cell_ctl_t;

endpackage

### rtl/mpow_if.sv
`timescale 1ns / 1ps
// Handshake channels: matrix entries, result entries, size register writes.
interface mpow_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [mpow_pkg::DATA_W-1:0] entry_value;
	logic        [mpow_pkg::PWR_W-1:0]  power;
	modport source (output valid, entry_value, power, input ready);
	modport sink (input valid, entry_value, power, output ready);
endinterface

interface mpow_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [mpow_pkg::DATA_W-1:0] result_value;
	logic        [mpow_pkg::IDX_W-1:0]  row_index;
	logic        [mpow_pkg::IDX_W-1:0]  col_index;
	logic                               last_entry;
	modport source (output valid, result_value, row_index, col_index, last_entry, input ready);
	modport sink (input valid, result_value, row_index, col_index, last_entry, output ready);
endinterface

interface mpow_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mpow_pkg::SIZE_W-1:0]       matrix_size;
	modport source (output valid, matrix_size, input ready);
	modport sink (input valid, matrix_size, output ready);
endinterface

### rtl/mpow_cell.sv
`timescale 1ns / 1ps
// One column cell: holds a column of base, accumulator and new product; one MAC.
module mpow_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mpow_pkg::IDX_W-1:0] cell_id,
	input  mpow_pkg::cell_ctl_t        ctl,
	input  mpow_pkg::token_t           tk_in,
	output mpow_pkg::token_t           tk_out,
	output mpow_pkg::col_t             acc_col
);

	mpow_pkg::col_t base_q;
	mpow_pkg::col_t acc_q;
	mpow_pkg::col_t new_q;

	mpow_pkg::token_t              tk_q;
	logic                          v_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic [mpow_pkg::IDX_W-1:0]    row_s1;
	logic [mpow_pkg::DATA_W-1:0]   prod_s1;
	logic [mpow_pkg::DATA_W-1:0]   sum_q;
	logic [mpow_pkg::DATA_W-1:0]   rhs;
	logic [mpow_pkg::DATA_W-1:0]   sum_nxt;

	assign rhs     = ctl.use_base ? base_q[tk_in.t] : acc_q[tk_in.t];
	assign sum_nxt = first_s1 ? prod_s1 : sum_q + prod_s1;
	assign tk_out  = tk_q;
	assign acc_col = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			tk_q <= tk_in;
			v_s1 <= tk_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		first_s1   <= tk_in.first;
		last_s1    <= tk_in.last;
		row_s1     <= tk_in.row;
		prod_s1    <= tk_in.a * rhs;
		if (v_s1) begin
			sum_q <= sum_nxt;
			if (last_s1)
				new_q[row_s1] <= sum_nxt;
		end
		if (ctl.load_we && ctl.load_col == cell_id)
			base_q[ctl.load_row] <= ctl.load_data;
		if (ctl.init) begin
			for (int r = 0; r < mpow_pkg::MAX_SIZE; r++)
				acc_q[r] <= (mpow_pkg::IDX_W'(r) == cell_id) ? 32'd1 : 32'd0;
		end else if (ctl.copy) begin
			acc_q <= new_q;
		end
	end

endmodule

### rtl/matrix_power_by_squaring.sv
`timescale 1ns / 1ps
// Sequence: k*k load items, a set-up state, then 31 squaring passes plus one multiply pass per
// set exponent bit, each pass issuing k*k products and then draining; then k*k results.
// Throughput: one entry per cycle while loading with no size write; one matrix per computation.
// Passes run on a row of MAX_SIZE column cells, one MAC each, operands handed cell to cell.
// Reset: asynchronous active low; size returns to 2, load position to 0, no result pending.
module matrix_power_by_squaring (
	input  logic          clk,
	input  logic          arst_n,
	mpow_in_if.sink       entries,
	mpow_out_if.source    results,
	mpow_cfg_if.sink      cfg
);

	typedef enum logic [2:0] {ST_LOAD, ST_INIT, ST_ISSUE, ST_DRAIN, ST_OUT} state_t;

	state_t                          state_q;
	logic [mpow_pkg::SIZE_W-1:0]     size_q;
	logic [mpow_pkg::SIZE_W-1:0]     k;
	logic [mpow_pkg::IDX_W-1:0]      km1;
	logic [mpow_pkg::IDX_W-1:0]      r_q;
	logic [mpow_pkg::IDX_W-1:0]      c_q;
	logic [mpow_pkg::PWR_W-1:0]      pwr_q;
	logic [mpow_pkg::BIT_W-1:0]      bit_q;
	logic                            mul_q;
	logic [mpow_pkg::DRAIN_W-1:0]    drain_q;
	logic                            ov_q;
	logic [mpow_pkg::DATA_W-1:0]     ovalue_q;
	logic [mpow_pkg::IDX_W-1:0]      orow_q;
	logic [mpow_pkg::IDX_W-1:0]      ocol_q;
	logic                            olast_q;

	mpow_pkg::cell_ctl_t             ctl;
	mpow_pkg::token_t                tk0_q;
	mpow_pkg::token_t                chain [mpow_pkg::MAX_SIZE+1];
	mpow_pkg::col_t                  acc_cols [mpow_pkg::MAX_SIZE];

	logic entry_acc;
	logic at_end;
	logic out_load;

	// size 0 acts as 1, above MAX_SIZE as MAX_SIZE
	assign k = (size_q == '0) ? mpow_pkg::SIZE_W'(1) :
		(size_q > mpow_pkg::SIZE_W'(mpow_pkg::MAX_SIZE)) ?
		mpow_pkg::SIZE_W'(mpow_pkg::MAX_SIZE) : size_q;
	assign km1 = mpow_pkg::IDX_W'(k - mpow_pkg::SIZE_W'(1));

	// a size write takes the cycle; no entry is taken alongside it
	assign entries.ready = (state_q == ST_LOAD) && !cfg.valid;
	assign cfg.ready     = (state_q == ST_LOAD);
	assign entry_acc     = entries.valid && entries.ready;
	assign at_end        = (r_q == km1) && (c_q == km1);
	assign out_load      = (state_q == ST_OUT) && (!ov_q || results.ready);

	assign results.valid        = ov_q;
	assign results.result_value = ovalue_q;
	assign results.row_index    = orow_q;
	assign results.col_index    = ocol_q;
	assign results.last_entry   = olast_q;

	always_comb begin
		ctl.init      = (state_q == ST_INIT);
		ctl.copy      = (state_q == ST_DRAIN) && (drain_q == mpow_pkg::DRAIN_LEN);
		ctl.use_base  = mul_q;
		ctl.load_we   = entry_acc;
		ctl.load_row  = r_q;
		ctl.load_col  = c_q;
		ctl.load_data = entries.entry_value;
	end

	assign chain[0] = tk0_q;

	for (genvar g = 0; g < mpow_pkg::MAX_SIZE; g++) begin : g_cell
		mpow_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (mpow_pkg::IDX_W'(g)),
			.ctl     (ctl),
			.tk_in   (chain[g]),
			.tk_out  (chain[g+1]),
			.acc_col (acc_cols[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			size_q      <= mpow_pkg::SIZE_RST;
			r_q         <= '0;
			c_q         <= '0;
			bit_q       <= '0;
			mul_q       <= 1'b0;
			drain_q     <= '0;
			ov_q        <= 1'b0;
			tk0_q       <= '0;
		end else begin
			// c_q walks the inner index t, r_q the output row
			tk0_q.valid <= (state_q == ST_ISSUE);
			tk0_q.first <= (c_q == '0);
			tk0_q.last  <= (c_q == km1);
			tk0_q.row   <= r_q;
			tk0_q.t     <= c_q;
			tk0_q.a     <= acc_cols[c_q][r_q];
			if (out_load)
				ov_q <= 1'b1;
			else if (results.ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (cfg.valid) begin
						size_q <= cfg.matrix_size;
						r_q    <= '0;
						c_q    <= '0;
					end else if (entry_acc) begin
						if (at_end) begin
							state_q <= ST_INIT;
							r_q     <= '0;
							c_q     <= '0;
						end else if (c_q == km1) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				ST_INIT: begin
					state_q <= ST_ISSUE;
					bit_q   <= mpow_pkg::BIT_W'(mpow_pkg::PWR_W - 1);
					mul_q   <= 1'b0;
				end
				ST_ISSUE: begin
					if (at_end) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
						r_q     <= '0;
						c_q     <= '0;
					end else if (c_q == km1) begin
						c_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (ctl.copy) begin
						if (!mul_q && pwr_q[bit_q]) begin
							mul_q   <= 1'b1;
							state_q <= ST_ISSUE;
						end else if (bit_q == '0) begin
							mul_q   <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							mul_q   <= 1'b0;
							bit_q   <= bit_q - 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						if (at_end) begin
							state_q <= ST_LOAD;
							r_q     <= '0;
							c_q     <= '0;
						end else if (c_q == km1) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (entry_acc && at_end)
			pwr_q <= entries.power;
		if (out_load) begin
			ovalue_q <= acc_cols[c_q][r_q];
			orow_q   <= r_q;
			ocol_q   <= c_q;
			olast_q  <= at_end;
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for matrix_power_by_squaring: random matrices and exponents checked against a predictor.

typedef struct packed {
	logic [mpow_pkg::DATA_W-1:0] value;
	logic [mpow_pkg::IDX_W-1:0]  row;
	logic [mpow_pkg::IDX_W-1:0]  col;
	logic                        last;
} mpow_entry_t;

class mpow_scoreboard;
	logic [mpow_pkg::DATA_W-1:0] base_m [mpow_pkg::MAX_SIZE][mpow_pkg::MAX_SIZE];
	int unsigned fill;
	logic [mpow_pkg::SIZE_W-1:0] size_reg;
	mpow_entry_t pending [$];
	int errors;

	function new();
		fill = 0;
		size_reg = mpow_pkg::SIZE_RST;
		errors = 0;
	endfunction

	function int unsigned side();
		if (size_reg == 0) return 1;
		if (size_reg > mpow_pkg::MAX_SIZE) return mpow_pkg::MAX_SIZE;
		return size_reg;
	endfunction

	function void set_size(logic [mpow_pkg::SIZE_W-1:0] s);
		size_reg = s;
		fill = 0;
	endfunction

	// acc := acc * rhs, all wrapped to 32 bits
	function void mat_mul(ref logic [mpow_pkg::DATA_W-1:0] acc [mpow_pkg::MAX_SIZE][mpow_pkg::MAX_SIZE],
			input logic [mpow_pkg::DATA_W-1:0] rhs [mpow_pkg::MAX_SIZE][mpow_pkg::MAX_SIZE],
			input int unsigned k);
		logic [mpow_pkg::DATA_W-1:0] prod [mpow_pkg::MAX_SIZE][mpow_pkg::MAX_SIZE];
		logic [mpow_pkg::DATA_W-1:0] sum;
		for (int r = 0; r < k; r++)
			for (int c = 0; c < k; c++) begin
				sum = '0;
				for (int t = 0; t < k; t++)
					sum = sum + acc[r][t] * rhs[t][c];
				prod[r][c] = sum;
			end
		for (int r = 0; r < k; r++)
			for (int c = 0; c < k; c++)
				acc[r][c] = prod[r][c];
	endfunction

	function void note_entry(logic [mpow_pkg::DATA_W-1:0] v, logic [mpow_pkg::PWR_W-1:0] p);
		int unsigned k;
		logic [mpow_pkg::DATA_W-1:0] acc [mpow_pkg::MAX_SIZE][mpow_pkg::MAX_SIZE];
		logic [mpow_pkg::DATA_W-1:0] sq [mpow_pkg::MAX_SIZE][mpow_pkg::MAX_SIZE];
		mpow_entry_t e;
		k = side();
		base_m[fill / k][fill % k] = v;
		fill++;
		if (fill < k * k) return;
		fill = 0;
		for (int r = 0; r < mpow_pkg::MAX_SIZE; r++)
			for (int c = 0; c < mpow_pkg::MAX_SIZE; c++)
				acc[r][c] = (r == c) ? mpow_pkg::DATA_W'(1) : '0;
		for (int b = mpow_pkg::PWR_W - 1; b >= 0; b--) begin
			sq = acc;
			mat_mul(acc, sq, k);
			if (p[b]) mat_mul(acc, base_m, k);
		end
		for (int r = 0; r < k; r++)
			for (int c = 0; c < k; c++) begin
				e.value = acc[r][c];
				e.row = mpow_pkg::IDX_W'(r);
				e.col = mpow_pkg::IDX_W'(c);
				e.last = (r == k - 1) && (c == k - 1);
				pending.push_back(e);
			end
	endfunction

	function void check_result(mpow_entry_t got);
		mpow_entry_t exp_e;
		if (pending.size() == 0) begin
			$error("unexpected result value=%0h", got.value);
			errors++;
			return;
		end
		exp_e = pending.pop_front();
		if (got.value !== exp_e.value) begin
			$error("result_value exp %0h got %0h", exp_e.value, got.value); errors++;
		end
		if (got.row !== exp_e.row) begin
			$error("row_index exp %0d got %0d", exp_e.row, got.row); errors++;
		end
		if (got.col !== exp_e.col) begin
			$error("col_index exp %0d got %0d", exp_e.col, got.col); errors++;
		end
		if (got.last !== exp_e.last) begin
			$error("last_entry exp %0b got %0b", exp_e.last, got.last); errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	longint unsigned cycles = 0;
	bit stim_done = 0;
	mpow_scoreboard sb = new();

	mpow_in_if  entries();
	mpow_out_if results();
	mpow_cfg_if cfg();

	matrix_power_by_squaring i_dut (
		.clk(clk), .arst_n(arst_n), .entries(entries), .results(results), .cfg(cfg)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		entries.valid = 0;
		entries.entry_value = '0;
		entries.power = '0;
		cfg.valid = 0;
		cfg.matrix_size = '0;
		results.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd4000000) begin
			$display("[matrix_power_by_squaring] ERROR");
			$finish;
		end
	end

	// sink: random stalls, sampled at the rising edge
	initial begin
		int w;
		mpow_entry_t got;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if ($urandom_range(0, 4) == 0) w = 0;
			results.ready = 0;
			repeat (w) @(negedge clk);
			results.ready = 1;
			do @(posedge clk); while (!results.valid);
			got.value = results.result_value;
			got.row = results.row_index;
			got.col = results.col_index;
			got.last = results.last_entry;
			sb.check_result(got);
		end
	end

	task automatic send_entry(logic [mpow_pkg::DATA_W-1:0] v, logic [mpow_pkg::PWR_W-1:0] p,
			int gap);
		repeat (gap) @(negedge clk);
		entries.valid = 1;
		entries.entry_value = v;
		entries.power = p;
		do @(posedge clk); while (!entries.ready);
		sb.note_entry(v, p);
		@(negedge clk);
		entries.valid = 0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_size(logic [mpow_pkg::SIZE_W-1:0] s);
		wait_drained();
		cfg.valid = 1;
		cfg.matrix_size = s;
		do @(posedge clk); while (!cfg.ready);
		sb.set_size(s);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	function automatic logic [mpow_pkg::DATA_W-1:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'hffffffff;
			3: return $urandom_range(0, 4) - 2;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [mpow_pkg::PWR_W-1:0] rand_pow();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return mpow_pkg::PWR_W'(1);
			2: return 31'h7fffffff;
			3: return mpow_pkg::PWR_W'($urandom_range(2, 9));
			default: return mpow_pkg::PWR_W'($urandom);
		endcase
	endfunction

	task automatic send_matrix(int unsigned k, bit fast);
		for (int i = 0; i < k * k; i++)
			send_entry(rand_val(), rand_pow(), fast ? 0 : $urandom_range(0, 15));
	endtask

	initial begin
		int sent;
		int unsigned k;
		logic [mpow_pkg::SIZE_W-1:0] sizes [6];
		sizes = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd2};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// default size 2: identity power, power one, extremes
		send_entry(32'h7fffffff, 0, 0); send_entry(32'h80000000, 0, 0);
		send_entry(32'hffffffff, 0, 0); send_entry(32'h00000001, 0, 0);
		send_entry(32'h7fffffff, 1, 1); send_entry(32'h80000000, 1, 0);
		send_entry(32'hffffffff, 1, 2); send_entry(32'h00000000, 1, 0);
		// Fibonacci-style matrix, maximum exponent
		send_entry(1, 0, 0); send_entry(1, 0, 0); send_entry(1, 0, 0);
		send_entry(0, 31'h7fffffff, 0);
		// partial load discarded by a size write
		send_entry(32'h12345678, 0, 0);
		write_size(4'd1);
		send_entry(32'h80000000, 31'h55555555, 0);
		send_entry(32'h00000003, 31'h2aaaaaaa, 0);
		sent = 15;
		write_size(4'd8);
		send_matrix(8, 1);
		sent += 64;
		wait_drained();
		while (sent < 310) begin
			write_size(sizes[$urandom_range(0, 5)]);
			k = sb.side();
			repeat ($urandom_range(1, 4)) begin
				if (sent >= 310) break;
				if (k >= 5 && $urandom_range(0, 2) != 0) break;
				send_matrix(k, $urandom_range(0, 3) == 0);
				sent += k * k;
			end
		end
		wait_drained();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[matrix_power_by_squaring] OK");
		end else begin
			$display("[matrix_power_by_squaring] ERROR");
		end
		$finish;
	end
endmodule
